FILE: rtl/hdbn_pkg.sv
// ----------------------------------------------------------------------------
// hdbn_pkg: shared types and constants of the HDBn line encoder
// Ternary symbol codes, zero limit bounds and the per-item emit plan.
// ----------------------------------------------------------------------------
package hdbn_pkg;

    localparam int CNT_W = 4;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic signed [1:0] sym_t;

    localparam sym_t SYM_ZERO = 2'sb00;
    localparam sym_t SYM_POS  = 2'sb01;
    localparam sym_t SYM_NEG  = 2'sb11;

    localparam cnt_t LIMIT_RESET = 4'd3;
    localparam cnt_t LIMIT_MIN   = 4'd1;
    localparam cnt_t LIMIT_MAX   = 4'd8;

    // what one accepted item emits: symbols 0..final_idx, all zero except
    // the final one and, for a substitution, the B slot at b_pos
    typedef struct packed {
        logic has_out;
        cnt_t final_idx;
        logic has_b;
        cnt_t b_pos;
        sym_t final_n;
        sym_t final_p;
        sym_t b_n;
        sym_t b_p;
        logic msg_last;
    } plan_t;

    function automatic sym_t pol_sym(input logic pos);
        return pos ? SYM_POS : SYM_NEG;
    endfunction

endpackage

FILE: rtl/hdbn_plan.sv
// ----------------------------------------------------------------------------
// hdbn_plan: encoder state and emit plan
// Holds the zero run and the mark/violation polarities of both streams and
// works out, for the item at the input, which symbols it releases.
// ----------------------------------------------------------------------------
module hdbn_plan
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic          data_bit,
    input  logic          msg_last,
    input  hdbn_pkg::cnt_t limit,
    output hdbn_pkg::plan_t plan
);

    hdbn_pkg::cnt_t pending_reg, pending_next;
    logic mark_n_reg, viol_n_reg, mark_p_reg, viol_p_reg;
    logic mark_n_next, viol_n_next, mark_p_next, viol_p_next;

    hdbn_pkg::cnt_t cnt;
    logic           subst;

    assign cnt   = pending_reg + 4'd1;
    assign subst = !data_bit && (cnt > limit);

    always_comb
    begin
        plan           = '0;
        plan.has_out   = data_bit || subst || msg_last;
        plan.final_idx = pending_reg;
        plan.has_b     = subst;
        plan.b_pos     = pending_reg - limit;
        plan.final_n   = hdbn_pkg::SYM_ZERO;
        plan.final_p   = hdbn_pkg::SYM_ZERO;
        plan.b_n       = hdbn_pkg::SYM_ZERO;
        plan.b_p       = hdbn_pkg::SYM_ZERO;
        plan.msg_last  = msg_last;

        pending_next = cnt;
        mark_n_next  = mark_n_reg;
        viol_n_next  = viol_n_reg;
        mark_p_next  = mark_p_reg;
        viol_p_next  = viol_p_reg;

        if (data_bit)
        begin
            // alternate mark inversion
            mark_n_next   = !mark_n_reg;
            mark_p_next   = !mark_p_reg;
            plan.final_n  = hdbn_pkg::pol_sym(!mark_n_reg);
            plan.final_p  = hdbn_pkg::pol_sym(!mark_p_reg);
            pending_next  = '0;
        end
        else if (subst)
        begin
            // B0..0V, B only when last mark matches last violation
            plan.final_n = hdbn_pkg::pol_sym(!viol_n_reg);
            plan.final_p = hdbn_pkg::pol_sym(!viol_p_reg);
            if (mark_n_reg == viol_n_reg)
                plan.b_n = hdbn_pkg::pol_sym(!viol_n_reg);
            if (mark_p_reg == viol_p_reg)
                plan.b_p = hdbn_pkg::pol_sym(!viol_p_reg);
            mark_n_next  = !viol_n_reg;
            viol_n_next  = !viol_n_reg;
            mark_p_next  = !viol_p_reg;
            viol_p_next  = !viol_p_reg;
            pending_next = '0;
        end

        if (msg_last)
        begin
            pending_next = '0;
            mark_n_next  = 1'b0;
            viol_n_next  = 1'b1;
            mark_p_next  = 1'b0;
            viol_p_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            mark_n_reg  <= 1'b0;
            viol_n_reg  <= 1'b1;
            mark_p_reg  <= 1'b0;
            viol_p_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
            mark_n_reg  <= mark_n_next;
            viol_n_reg  <= viol_n_next;
            mark_p_reg  <= mark_p_next;
            viol_p_reg  <= viol_p_next;
        end
    end

endmodule

FILE: rtl/hdbn_emit.sv
// ----------------------------------------------------------------------------
// hdbn_emit: symbol sequencer and output register
// Holds one item's plan, steps through its symbols one per cycle while the
// output is not stalled, and drives the output register.
// ----------------------------------------------------------------------------
module hdbn_emit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  hdbn_pkg::plan_t       plan_in,
    output logic                  load_ok,
    output logic                  out_valid,
    input  logic                  out_stall,
    output hdbn_pkg::sym_t        sym_n,
    output hdbn_pkg::sym_t        sym_p,
    output logic                  run_last,
    output logic                  msg_end
);

    hdbn_pkg::plan_t plan_reg;
    logic            plan_valid_reg;
    hdbn_pkg::cnt_t  idx_reg;

    logic           out_valid_reg;
    hdbn_pkg::sym_t sym_n_reg, sym_p_reg;
    logic           run_last_reg, msg_end_reg;

    logic           out_free, emit, is_final, plan_done;
    hdbn_pkg::sym_t cur_n, cur_p;

    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = plan_valid_reg && out_free;
    assign is_final  = (idx_reg == plan_reg.final_idx);
    assign plan_done = emit && is_final;
    assign load_ok   = !plan_valid_reg || plan_done;

    always_comb
    begin
        cur_n = hdbn_pkg::SYM_ZERO;
        cur_p = hdbn_pkg::SYM_ZERO;
        if (is_final)
        begin
            cur_n = plan_reg.final_n;
            cur_p = plan_reg.final_p;
        end
        else if (plan_reg.has_b && (idx_reg == plan_reg.b_pos))
        begin
            cur_n = plan_reg.b_n;
            cur_p = plan_reg.b_p;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plan_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else if (load)
        begin
            plan_valid_reg <= 1'b1;
            idx_reg        <= '0;
        end
        else if (plan_done)
        begin
            plan_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            idx_reg <= idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            plan_reg <= plan_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            sym_n_reg    <= cur_n;
            sym_p_reg    <= cur_p;
            run_last_reg <= is_final;
            msg_end_reg  <= is_final && plan_reg.msg_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign sym_n     = sym_n_reg;
    assign sym_p     = sym_p_reg;
    assign run_last  = run_last_reg;
    assign msg_end   = msg_end_reg;

endmodule

FILE: rtl/hdbn_line_encoder_top.sv
// ----------------------------------------------------------------------------
// hdbn_line_encoder_top: dual-stream HDBn line encoder
// Codes message bits into HDBn ternary symbols for the N and P streams.
// ----------------------------------------------------------------------------
// An item releases zero to nine results, one per cycle while the output is
// not stalled, through a single output register. The next item is taken in
// the cycle its last result is emitted, so items with one result or none
// flow at one per cycle while the output is not stalled. Zeros that do not
// settle a run are held in the encoder and emitted later. zero_limit is
// clamped to 1..8; the user must write it through the cfg port while the
// block is idle, and the block itself does not enforce this.
module hdbn_line_encoder_top
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  data_bit,
    input  logic                  msg_last,
    output logic                  out_valid,
    input  logic                  out_stall,
    output hdbn_pkg::sym_t        sym_n,
    output hdbn_pkg::sym_t        sym_p,
    output logic                  run_last,
    output logic                  msg_end,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [3:0]            cfg_data
);

    hdbn_pkg::cnt_t  zero_limit_reg;
    hdbn_pkg::cnt_t  limit;
    hdbn_pkg::plan_t plan;
    logic            load_ok, accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            zero_limit_reg <= hdbn_pkg::LIMIT_RESET;
        else if (cfg_valid && cfg_ready)
            zero_limit_reg <= cfg_data;
    end

    always_comb
    begin
        limit = zero_limit_reg;
        if (zero_limit_reg < hdbn_pkg::LIMIT_MIN)
            limit = hdbn_pkg::LIMIT_MIN;
        else if (zero_limit_reg > hdbn_pkg::LIMIT_MAX)
            limit = hdbn_pkg::LIMIT_MAX;
    end

    assign in_stall = !load_ok;
    assign accept   = in_valid && load_ok;

    hdbn_plan u_plan
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .data_bit (data_bit),
        .msg_last (msg_last),
        .limit    (limit),
        .plan     (plan)
    );

    hdbn_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && plan.has_out),
        .plan_in   (plan),
        .load_ok   (load_ok),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sym_n     (sym_n),
        .sym_p     (sym_p),
        .run_last  (run_last),
        .msg_end   (msg_end)
    );

endmodule

FILE: rtl/hdbn_checker.sv
// ----------------------------------------------------------------------------
// hdbn_checker: port-level checks of the HDBn line encoder
// Watches the result channel for legal symbols and consistent end flags.
// ----------------------------------------------------------------------------
module hdbn_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input hdbn_pkg::sym_t        sym_n,
    input hdbn_pkg::sym_t        sym_p,
    input logic                  run_last,
    input logic                  msg_end
);

    // a stalled item holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sym_n) && $stable(sym_p)
            && $stable(run_last) && $stable(msg_end))
        else $error("result item changed while stalled");

    // message end always closes an item's run
    a_end_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && msg_end |-> run_last)
        else $error("msg_end without run_last");

    a_sym_n_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sym_n != 2'sb10))
        else $error("illegal symbol on N stream");

    a_sym_p_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sym_p != 2'sb10))
        else $error("illegal symbol on P stream");

endmodule

bind hdbn_line_encoder_top hdbn_checker u_hdbn_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sym_n     (sym_n),
    .sym_p     (sym_p),
    .run_last  (run_last),
    .msg_end   (msg_end)
);
